FILE: rtl/core/pcfs_pkg.sv
// Shared types and constants of the point-charge field summation block.
package pcfs_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic [1:0] CFG_NUM_CHARGES  = 2'd0;
	localparam logic [1:0] CFG_FIELD_SCALE  = 2'd1;
	localparam logic [1:0] CFG_MIN_DISTANCE = 2'd2;

	localparam logic [1:0] SEL_POT = 2'd0;
	localparam logic [1:0] SEL_X   = 2'd1;
	localparam logic [1:0] SEL_Y   = 2'd2;
	localparam logic [1:0] SEL_Z   = 2'd3;

	localparam logic [3:0] MS_SQX  = 4'd0;
	localparam logic [3:0] MS_SQY  = 4'd1;
	localparam logic [3:0] MS_SQZ  = 4'd2;
	localparam logic [3:0] MS_AMAG = 4'd3;
	localparam logic [3:0] MS_DD   = 4'd4;
	localparam logic [3:0] MS_D3L  = 4'd5;
	localparam logic [3:0] MS_D3H  = 4'd6;
	localparam logic [3:0] MS_NL   = 4'd7;
	localparam logic [3:0] MS_NH   = 4'd8;

	localparam logic [6:0] SQRT_LAST = 7'd32;
	localparam logic [6:0] DIV_LAST  = 7'd127;

	typedef struct packed {
		logic       mem_wr;
		logic       load_q;
		logic       rd_en;
		logic       disp_en;
		logic       mul_en;
		logic [3:0] mul_sel;
		logic       mul_clr;
		logic       mul_sh;
		logic       save_amag;
		logic       save_d2;
		logic       save_d3;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       set_close;
		logic       div_init;
		logic       div_field;
		logic       div_step;
		logic       term_en;
		logic       sum_en;
		logic [1:0] sel;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic d_bad;
	} dp_stat_t;

endpackage

FILE: rtl/core/pcfs_ctrl.sv
// Controller state machine that sequences the per-charge arithmetic.
module pcfs_ctrl import pcfs_pkg::*; #(
	parameter int MAX_CHARGES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic [6:0] num_charges,
	input  dp_stat_t   stat,
	output dp_cmd_t    dcmd,
	output logic [$clog2(MAX_CHARGES + 1)-1:0] idx
);
	localparam int CW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES + 1) : 1;

	localparam logic [5:0] S_IDLE = 6'd0;
	localparam logic [5:0] S_RD   = 6'd1;
	localparam logic [5:0] S_DISP = 6'd2;
	localparam logic [5:0] S_SQX  = 6'd3;
	localparam logic [5:0] S_SQY  = 6'd4;
	localparam logic [5:0] S_SQZ  = 6'd5;
	localparam logic [5:0] S_SQW  = 6'd6;
	localparam logic [5:0] S_SQI  = 6'd7;
	localparam logic [5:0] S_SQS  = 6'd8;
	localparam logic [5:0] S_CHK  = 6'd9;
	localparam logic [5:0] S_AM   = 6'd10;
	localparam logic [5:0] S_AMW  = 6'd11;
	localparam logic [5:0] S_AMS  = 6'd12;
	localparam logic [5:0] S_PDI  = 6'd13;
	localparam logic [5:0] S_PDS  = 6'd14;
	localparam logic [5:0] S_PT   = 6'd15;
	localparam logic [5:0] S_PS   = 6'd16;
	localparam logic [5:0] S_D2M  = 6'd17;
	localparam logic [5:0] S_D2W  = 6'd18;
	localparam logic [5:0] S_D2S  = 6'd19;
	localparam logic [5:0] S_D3L  = 6'd20;
	localparam logic [5:0] S_D3H  = 6'd21;
	localparam logic [5:0] S_D3W  = 6'd22;
	localparam logic [5:0] S_D3S  = 6'd23;
	localparam logic [5:0] S_NL   = 6'd24;
	localparam logic [5:0] S_NH   = 6'd25;
	localparam logic [5:0] S_NW   = 6'd26;
	localparam logic [5:0] S_FDI  = 6'd27;
	localparam logic [5:0] S_FDS  = 6'd28;
	localparam logic [5:0] S_FT   = 6'd29;
	localparam logic [5:0] S_FS   = 6'd30;
	localparam logic [5:0] S_NXT  = 6'd31;
	localparam logic [5:0] S_FIN  = 6'd32;

	logic [5:0]    state_q, state_d;
	logic [6:0]    cnt_q;
	logic [1:0]    ax_q;
	logic [CW-1:0] idx_q, n_q, n_c;
	logic          out_valid_q;

	assign n_c = (32'(num_charges) > MAX_CHARGES) ? CW'(MAX_CHARGES) : CW'(num_charges);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign idx       = idx_q;

	always_comb begin
		dcmd    = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_LOAD) begin
						dcmd.mem_wr = 1'b1;
					end else begin
						dcmd.load_q = 1'b1;
						state_d = (n_c == '0) ? S_FIN : S_RD;
					end
				end
			end
			S_RD: begin
				dcmd.rd_en = 1'b1;
				state_d = S_DISP;
			end
			S_DISP: begin
				dcmd.disp_en = 1'b1;
				state_d = S_SQX;
			end
			S_SQX: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_SQX;
				dcmd.mul_clr = 1'b1;
				state_d = S_SQY;
			end
			S_SQY: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_SQY;
				state_d = S_SQZ;
			end
			S_SQZ: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_SQZ;
				state_d = S_SQW;
			end
			S_SQW: state_d = S_SQI;
			S_SQI: begin
				dcmd.sqrt_init = 1'b1;
				state_d = S_SQS;
			end
			S_SQS: begin
				dcmd.sqrt_step = 1'b1;
				if (cnt_q == SQRT_LAST) state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.d_bad) begin
					dcmd.set_close = 1'b1;
					state_d = S_NXT;
				end else begin
					state_d = S_AM;
				end
			end
			S_AM: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_AMAG;
				dcmd.mul_clr = 1'b1;
				state_d = S_AMW;
			end
			S_AMW: state_d = S_AMS;
			S_AMS: begin
				dcmd.save_amag = 1'b1;
				state_d = S_PDI;
			end
			S_PDI: begin
				dcmd.div_init = 1'b1;
				state_d = S_PDS;
			end
			S_PDS: begin
				dcmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_PT;
			end
			S_PT: begin
				dcmd.term_en = 1'b1;
				dcmd.sel = SEL_POT;
				state_d = S_PS;
			end
			S_PS: begin
				dcmd.sum_en = 1'b1;
				dcmd.sel = SEL_POT;
				state_d = S_D2M;
			end
			S_D2M: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_DD;
				dcmd.mul_clr = 1'b1;
				state_d = S_D2W;
			end
			S_D2W: state_d = S_D2S;
			S_D2S: begin
				dcmd.save_d2 = 1'b1;
				state_d = S_D3L;
			end
			S_D3L: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_D3L;
				dcmd.mul_clr = 1'b1;
				state_d = S_D3H;
			end
			S_D3H: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_D3H;
				dcmd.mul_sh = 1'b1;
				state_d = S_D3W;
			end
			S_D3W: state_d = S_D3S;
			S_D3S: begin
				dcmd.save_d3 = 1'b1;
				state_d = S_NL;
			end
			S_NL: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_NL;
				dcmd.mul_clr = 1'b1;
				dcmd.sel = ax_q;
				state_d = S_NH;
			end
			S_NH: begin
				dcmd.mul_en = 1'b1;
				dcmd.mul_sel = MS_NH;
				dcmd.mul_sh = 1'b1;
				dcmd.sel = ax_q;
				state_d = S_NW;
			end
			S_NW: state_d = S_FDI;
			S_FDI: begin
				dcmd.div_init = 1'b1;
				dcmd.div_field = 1'b1;
				state_d = S_FDS;
			end
			S_FDS: begin
				dcmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) state_d = S_FT;
			end
			S_FT: begin
				dcmd.term_en = 1'b1;
				dcmd.sel = ax_q;
				state_d = S_FS;
			end
			S_FS: begin
				dcmd.sum_en = 1'b1;
				dcmd.sel = ax_q;
				state_d = (ax_q == SEL_Z) ? S_NXT : S_NL;
			end
			S_NXT: begin
				state_d = (CW'(idx_q + 1'b1) == n_q) ? S_FIN : S_RD;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					dcmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ax_q        <= SEL_X;
			idx_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dcmd.load_q) begin
				n_q   <= n_c;
				idx_q <= '0;
			end
			if (state_q == S_NXT) idx_q <= CW'(idx_q + 1'b1);
			if (dcmd.sqrt_init || dcmd.div_init) begin
				cnt_q <= '0;
			end else if (dcmd.sqrt_step || dcmd.div_step) begin
				cnt_q <= cnt_q + 7'd1;
			end
			if (dcmd.save_d3) begin
				ax_q <= SEL_X;
			end else if (dcmd.sum_en && (ax_q != SEL_Z) && (dcmd.sel != SEL_POT)) begin
				ax_q <= ax_q + 2'd1;
			end
			if (dcmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/pcfs_dp.sv
// Datapath: charge table, multiplier with accumulator, square root, divider, sums.
module pcfs_dp import pcfs_pkg::*; #(
	parameter int MAX_CHARGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            dcmd,
	output dp_stat_t           stat,
	input  logic [$clog2(MAX_CHARGES + 1)-1:0] rd_idx,
	input  logic [5:0]         entry_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] charge_value,
	input  logic signed [31:0] field_scale,
	input  logic [30:0]        min_distance,
	output logic signed [63:0] potential,
	output logic signed [63:0] field_x,
	output logic signed [63:0] field_y,
	output logic signed [63:0] field_z,
	output logic               too_close
);
	localparam int AW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
	localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

	logic [127:0] mem_q [0:MAX_CHARGES-1];
	logic [127:0] rd_q;

	logic signed [31:0] qx_q, qy_q, qz_q;
	logic [32:0]  mx_q, my_q, mz_q;
	logic         nx_q, ny_q, nz_q, aneg_q;
	logic [32:0]  ma, mb, mag_ax;
	logic [65:0]  prod_s1;
	logic         acc_v_s1, clr_s1, sh_s1;
	logic [127:0] acc_q, addend;
	logic [62:0]  amag_q;
	logic [65:0]  d2_q;
	logic [98:0]  d3_q;
	logic [65:0]  rad_q;
	logic [35:0]  rem_q, rem_t, trial;
	logic [32:0]  root_q;
	logic [127:0] num_q;
	logic [98:0]  div_q;
	logic [99:0]  r_q, r_t;
	logic         neg_t, over_t;
	logic signed [63:0] term_q, term_c, sum_a;
	logic signed [64:0] sum_w;
	logic signed [63:0] sum_c;
	logic signed [63:0] pot_q, fx_q, fy_q, fz_q;
	logic         close_q;
	logic signed [32:0] dx_c, dy_c, dz_c;
	logic [32:0]  sc_mag, q_mag;
	logic signed [31:0] rq_x, rq_y, rq_z, rq_q;

	assign rq_x = rd_q[127:96];
	assign rq_y = rd_q[95:64];
	assign rq_z = rd_q[63:32];
	assign rq_q = rd_q[31:0];

	always_ff @(posedge clk) begin
		if (dcmd.mem_wr && (32'(entry_index) < MAX_CHARGES)) begin
			mem_q[AW'(entry_index)] <= {coord_x, coord_y, coord_z, charge_value};
		end
		if (dcmd.rd_en) rd_q <= mem_q[rd_idx[AW-1:0]];
	end

	assign dx_c = 33'(qx_q) - 33'(rq_x);
	assign dy_c = 33'(qy_q) - 33'(rq_y);
	assign dz_c = 33'(qz_q) - 33'(rq_z);
	assign sc_mag = field_scale[31] ? 33'(-34'(field_scale)) : 33'(field_scale);
	assign q_mag  = rq_q[31] ? 33'(-34'(rq_q)) : 33'(rq_q);

	always_comb begin
		case (dcmd.sel)
			SEL_X:   mag_ax = mx_q;
			SEL_Y:   mag_ax = my_q;
			default: mag_ax = mz_q;
		endcase
		case (dcmd.mul_sel)
			MS_SQX:  begin ma = mx_q; mb = mx_q; end
			MS_SQY:  begin ma = my_q; mb = my_q; end
			MS_SQZ:  begin ma = mz_q; mb = mz_q; end
			MS_AMAG: begin ma = sc_mag; mb = q_mag; end
			MS_DD:   begin ma = root_q; mb = root_q; end
			MS_D3L:  begin ma = d2_q[32:0]; mb = root_q; end
			MS_D3H:  begin ma = d2_q[65:33]; mb = root_q; end
			MS_NL:   begin ma = amag_q[32:0]; mb = mag_ax; end
			MS_NH:   begin ma = {3'b0, amag_q[62:33]}; mb = mag_ax; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign addend = sh_s1 ? ({62'b0, prod_s1} << 33) : {62'b0, prod_s1};

	assign trial = {1'b0, root_q, 2'b01};
	assign rem_t = {rem_q[33:0], rad_q[65:64]};
	assign r_t   = {r_q[98:0], num_q[127]};

	assign over_t = |num_q[127:63];
	always_comb begin
		neg_t = (dcmd.sel == SEL_POT) ? aneg_q :
			(dcmd.sel == SEL_X) ? (aneg_q ^ nx_q) :
			(dcmd.sel == SEL_Y) ? (aneg_q ^ ny_q) : (aneg_q ^ nz_q);
		if (over_t) term_c = neg_t ? SAT_MIN : SAT_MAX;
		else term_c = neg_t ? -$signed(num_q[63:0]) : $signed(num_q[63:0]);
		case (dcmd.sel)
			SEL_POT: sum_a = pot_q;
			SEL_X:   sum_a = fx_q;
			SEL_Y:   sum_a = fy_q;
			default: sum_a = fz_q;
		endcase
		sum_w = 65'(sum_a) + 65'(term_q);
		if (sum_w[64] != sum_w[63]) sum_c = sum_w[64] ? SAT_MIN : SAT_MAX;
		else sum_c = sum_w[63:0];
	end

	assign stat.d_bad = (root_q == '0) || (root_q < {2'b0, min_distance});

	always_ff @(posedge clk) begin
		if (dcmd.load_q) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
			qz_q <= coord_z;
		end
		if (dcmd.disp_en) begin
			mx_q   <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
			my_q   <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
			mz_q   <= dz_c[32] ? 33'(-dz_c) : 33'(dz_c);
			nx_q   <= dx_c[32];
			ny_q   <= dy_c[32];
			nz_q   <= dz_c[32];
			aneg_q <= field_scale[31] ^ rq_q[31];
		end
		prod_s1 <= ma * mb;
		clr_s1  <= dcmd.mul_clr;
		sh_s1   <= dcmd.mul_sh;
		if (acc_v_s1) acc_q <= (clr_s1 ? '0 : acc_q) + addend;
		if (dcmd.save_amag) amag_q <= acc_q[62:0];
		if (dcmd.save_d2) d2_q <= acc_q[65:0];
		if (dcmd.save_d3) d3_q <= acc_q[98:0];
		if (dcmd.sqrt_init) begin
			rad_q  <= acc_q[65:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (dcmd.sqrt_step) begin
			rad_q <= {rad_q[63:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q  <= rem_t - trial;
				root_q <= {root_q[31:0], 1'b1};
			end else begin
				rem_q  <= rem_t;
				root_q <= {root_q[31:0], 1'b0};
			end
		end
		if (dcmd.div_init) begin
			r_q <= '0;
			if (dcmd.div_field) begin
				num_q <= {acc_q[95:0], 32'b0};
				div_q <= d3_q;
			end else begin
				num_q <= {49'b0, amag_q, 16'b0};
				div_q <= {66'b0, root_q};
			end
		end else if (dcmd.div_step) begin
			if (r_t >= {1'b0, div_q}) begin
				r_q   <= r_t - {1'b0, div_q};
				num_q <= {num_q[126:0], 1'b1};
			end else begin
				r_q   <= r_t;
				num_q <= {num_q[126:0], 1'b0};
			end
		end
		if (dcmd.term_en) term_q <= term_c;
		if (dcmd.out_load) begin
			potential <= close_q ? '0 : pot_q;
			field_x   <= close_q ? '0 : fx_q;
			field_y   <= close_q ? '0 : fy_q;
			field_z   <= close_q ? '0 : fz_q;
			too_close <= close_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_v_s1 <= 1'b0;
			pot_q    <= '0;
			fx_q     <= '0;
			fy_q     <= '0;
			fz_q     <= '0;
			close_q  <= 1'b0;
		end else begin
			acc_v_s1 <= dcmd.mul_en;
			if (dcmd.load_q) begin
				pot_q   <= '0;
				fx_q    <= '0;
				fy_q    <= '0;
				fz_q    <= '0;
				close_q <= 1'b0;
			end else begin
				if (dcmd.set_close) close_q <= 1'b1;
				if (dcmd.sum_en) begin
					case (dcmd.sel)
						SEL_POT: pot_q <= sum_c;
						SEL_X:   fx_q  <= sum_c;
						SEL_Y:   fy_q  <= sum_c;
						default: fz_q  <= sum_c;
					endcase
				end
			end
		end
	end

endmodule

FILE: rtl/core/point_charge_field_sum.sv
// Top level of the point-charge potential and field summation block.
//
//   channel | handshake             | word
//   in      | in_valid / in_ready   | cmd, entry_index, coord_x/y/z, charge_value
//   out     | out_valid / out_ready | potential, field_x/y/z, too_close
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A load word writes one entry of the charge table. An evaluate word runs through each
// included charge in turn; a charge that is too close skips the bit-serial divider, which
// computes four quotients (potential and field x/y/z) for each other charge.
// Reset clears the controller and sums, presets the config; the charge table is not cleared.
// A stalled result holds in the output register while loads are still taken.
module point_charge_field_sum import pcfs_pkg::*; #(
	parameter int MAX_CHARGES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [5:0]         entry_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] charge_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] potential,
	output logic signed [63:0] field_x,
	output logic signed [63:0] field_y,
	output logic signed [63:0] field_z,
	output logic               too_close,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int CW = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES + 1) : 1;

	logic [6:0]         num_charges_q;
	logic signed [31:0] field_scale_q;
	logic [30:0]        min_distance_q;
	dp_cmd_t            dcmd;
	dp_stat_t           stat;
	logic [CW-1:0]      idx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_charges_q  <= '0;
			field_scale_q  <= 32'sd65536;
			min_distance_q <= 31'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_CHARGES:  num_charges_q  <= cfg_data[6:0];
				CFG_FIELD_SCALE:  field_scale_q  <= cfg_data;
				CFG_MIN_DISTANCE: min_distance_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	pcfs_ctrl #(.MAX_CHARGES(MAX_CHARGES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.num_charges (num_charges_q),
		.stat        (stat),
		.dcmd        (dcmd),
		.idx         (idx)
	);

	pcfs_dp #(.MAX_CHARGES(MAX_CHARGES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.dcmd         (dcmd),
		.stat         (stat),
		.rd_idx       (idx),
		.entry_index  (entry_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.charge_value (charge_value),
		.field_scale  (field_scale_q),
		.min_distance (min_distance_q),
		.potential    (potential),
		.field_x      (field_x),
		.field_y      (field_y),
		.field_z      (field_z),
		.too_close    (too_close)
	);

endmodule
